// File: src/spnc_pkg.sv
// Shared types and constants for the segment projection and near-plane clip block.
`default_nettype none

package spnc_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PIXEL_BITS = 16;
  localparam int COEF_BITS  = 32;

  localparam int CFG_W     = 2 * COEF_BITS;
  localparam int CFG_REGS  = 6;
  localparam int CFG_IDX_W = 3;

  // product, camera coordinate and clip divider widths
  localparam int PROD_W = COEF_BITS + COORD_BITS;
  localparam int CAM_W  = PROD_W + 2;
  localparam int DEN_W  = CAM_W + 1;

  // near plane 0.1 at 2*FRAC_BITS fraction bits, rounded to nearest
  localparam longint unsigned NEAR_Q = ((64'd1 << (2 * FRAC_BITS)) + 64'd5) / 64'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_A = 3'd0,
    REG_ROW0_B = 3'd1,
    REG_ROW1_A = 3'd2,
    REG_ROW1_B = 3'd3,
    REG_ROW2_A = 3'd4,
    REG_ROW2_B = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
  } spnc_in_t;

  typedef struct packed {
    logic                         visible;
    logic signed [PIXEL_BITS-1:0] start_u;
    logic signed [PIXEL_BITS-1:0] start_v;
    logic signed [PIXEL_BITS-1:0] end_u;
    logic signed [PIXEL_BITS-1:0] end_v;
  } spnc_out_t;

endpackage

`default_nettype wire

// File: src/segment_projection_near_clip_core.sv
// Segment projection: 3x4 matrix transform, near-plane clip and pixel divide, fully pipelined.
//
// A segment is taken on every cycle that start is high; busy is never raised. Each segment
// gives exactly one result, shown for one cycle with out_valid. It passes the product and
// row-sum registers of the matrix multiply, a near-plane test register, a 32-stage restoring
// divider for the clip factor, a first and a second clip interpolation register, PIXEL_BITS
// stages of pixel division and an output register.
// Results leave in input order and cannot be held off. Write the matrix registers only
// while no segment is in flight.
`default_nettype none

module segment_projection_near_clip_core
  import spnc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire spnc_in_t             in_data,
  output logic                      out_valid,
  output spnc_out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int DIV_STEPS = 32;
  localparam int DH_W      = DEN_W - 32;
  localparam int MH_W      = DH_W + 33;
  localparam int PSTEPS    = PIXEL_BITS - 1;
  localparam int CMP_W     = CAM_W + PIXEL_BITS;

  localparam logic signed [CAM_W-1:0] NEAR_Z = CAM_W'(NEAR_Q);
  localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
  localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

  typedef struct packed {
    logic                    vld;
    logic                    vis;
    logic                    clip;
    logic                    sel;   // first endpoint is the hidden one
    logic signed [CAM_W-1:0] ax, ay, az, bx, by, bz;
    logic [DEN_W-1:0]        rem;
    logic [DEN_W-1:0]        den;
    logic [31:0]             t;
  } clip_st_t;

  typedef struct packed {
    logic                    vld;
    logic                    vis;
    logic                    clip;
    logic                    sel;
    logic signed [CAM_W-1:0] ax, ay, az, bx, by, bz;
    logic signed [MH_W-1:0]  mhx, mhy;
    logic [31:0]             mlx, mly;
  } interp_st_t;

  typedef struct packed {
    logic                    neg;
    logic                    sat;
    logic [CAM_W-1:0]        m;
    logic [CAM_W-1:0]        z;
    logic [PIXEL_BITS-2:0]   q;
  } lane_t;

  typedef struct packed {
    logic      vld;
    logic      vis;
    lane_t [3:0] ln;
  } pix_st_t;

  // configuration
  logic [CFG_W-1:0] cfg_r [CFG_REGS];
  logic signed [COEF_BITS-1:0] coef [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_we && cfg_index <= REG_ROW2_B) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = (c % 2 == 1) ? cfg_r[r*2 + c/2][CFG_W-1:COEF_BITS]
                                  : cfg_r[r*2 + c/2][COEF_BITS-1:0];
      end
    end
  end

  assign busy = 1'b0;

  // stage 1: products
  logic signed [COORD_BITS-1:0] pt [2][3];
  logic signed [PROD_W-1:0] prod_r [2][3][3];
  logic vld1_r;

  always_comb begin
    pt[0][0] = in_data.start_x;
    pt[0][1] = in_data.start_y;
    pt[0][2] = in_data.start_z;
    pt[1][0] = in_data.end_x;
    pt[1][1] = in_data.end_y;
    pt[1][2] = in_data.end_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= start;
    end
    for (int e = 0; e < 2; e++)
      for (int r = 0; r < 3; r++)
        for (int j = 0; j < 3; j++)
          prod_r[e][r][j] <= PROD_W'(coef[r][j]) * PROD_W'(pt[e][j]);
  end

  // stage 2: row sums with translation
  logic signed [CAM_W-1:0] cam_r [2][3];
  logic vld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    for (int e = 0; e < 2; e++)
      for (int r = 0; r < 3; r++)
        cam_r[e][r] <= (CAM_W'(coef[r][3]) <<< FRAC_BITS)
                     + CAM_W'(prod_r[e][r][0]) + CAM_W'(prod_r[e][r][1])
                     + CAM_W'(prod_r[e][r][2]);
  end

  // stage 3: near-plane test, pick hidden endpoint, set up divider
  clip_st_t div_r [DIV_STEPS+1];
  clip_st_t setup_nxt;
  logic v1, v2;

  always_comb begin
    v1 = cam_r[0][2] > NEAR_Z;
    v2 = cam_r[1][2] > NEAR_Z;
    setup_nxt.vld  = vld2_r;
    setup_nxt.vis  = v1 | v2;
    setup_nxt.clip = (v1 | v2) & ~(v1 & v2);
    setup_nxt.sel  = ~v1;
    if (!v1) begin
      setup_nxt.ax = cam_r[0][0];
      setup_nxt.ay = cam_r[0][1];
      setup_nxt.az = cam_r[0][2];
      setup_nxt.bx = cam_r[1][0];
      setup_nxt.by = cam_r[1][1];
      setup_nxt.bz = cam_r[1][2];
    end else begin
      setup_nxt.ax = cam_r[1][0];
      setup_nxt.ay = cam_r[1][1];
      setup_nxt.az = cam_r[1][2];
      setup_nxt.bx = cam_r[0][0];
      setup_nxt.by = cam_r[0][1];
      setup_nxt.bz = cam_r[0][2];
    end
    setup_nxt.rem = DEN_W'(NEAR_Z) - DEN_W'(setup_nxt.az);
    setup_nxt.den = DEN_W'(setup_nxt.bz) - DEN_W'(setup_nxt.az);
    setup_nxt.t   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r[0].vld <= 1'b0;
    end else begin
      div_r[0] <= setup_nxt;
    end
  end

  // clip factor: one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DEN_W:0] rsh;
    logic           ge;
    clip_st_t       step_nxt;

    always_comb begin
      rsh      = {div_r[k].rem, 1'b0};
      ge       = rsh >= {1'b0, div_r[k].den};
      step_nxt = div_r[k];
      step_nxt.rem = ge ? DEN_W'(rsh - {1'b0, div_r[k].den}) : rsh[DEN_W-1:0];
      step_nxt.t   = {div_r[k].t[30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[k+1].vld <= 1'b0;
      end else begin
        div_r[k+1] <= step_nxt;
      end
    end
  end

  // interpolation, first half: t times (B - A), split at bit 32
  clip_st_t   dv;
  interp_st_t ip_r;
  interp_st_t ip_nxt;
  logic signed [DEN_W-1:0] dx, dy;
  logic [63:0] plx, ply;

  always_comb begin
    dv  = div_r[DIV_STEPS];
    dx  = DEN_W'(dv.bx) - DEN_W'(dv.ax);
    dy  = DEN_W'(dv.by) - DEN_W'(dv.ay);
    plx = {32'd0, dx[31:0]} * {32'd0, dv.t};
    ply = {32'd0, dy[31:0]} * {32'd0, dv.t};
    ip_nxt.vld  = dv.vld;
    ip_nxt.vis  = dv.vis;
    ip_nxt.clip = dv.clip;
    ip_nxt.sel  = dv.sel;
    ip_nxt.ax   = dv.ax;
    ip_nxt.ay   = dv.ay;
    ip_nxt.az   = dv.az;
    ip_nxt.bx   = dv.bx;
    ip_nxt.by   = dv.by;
    ip_nxt.bz   = dv.bz;
    ip_nxt.mhx  = MH_W'($signed(dx[DEN_W-1:32])) * MH_W'($signed({1'b0, dv.t}));
    ip_nxt.mhy  = MH_W'($signed(dy[DEN_W-1:32])) * MH_W'($signed({1'b0, dv.t}));
    ip_nxt.mlx  = plx[63:32];
    ip_nxt.mly  = ply[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r.vld <= 1'b0;
    end else begin
      ip_r <= ip_nxt;
    end
  end

  // interpolation, second half: move hidden endpoint, restore endpoint order
  pix_st_t pix_r [PSTEPS+1];
  pix_st_t lanes_nxt;
  pix_st_t prep_nxt;
  logic signed [CAM_W-1:0] nax, nay, naz;
  logic signed [CAM_W-1:0] lx [4];
  pix_st_t lanes_r;

  always_comb begin
    nax = ip_r.ax;
    nay = ip_r.ay;
    naz = ip_r.az;
    if (ip_r.clip) begin
      nax = CAM_W'(MH_W'(ip_r.ax) + ip_r.mhx + MH_W'($signed({1'b0, ip_r.mlx})));
      nay = CAM_W'(MH_W'(ip_r.ay) + ip_r.mhy + MH_W'($signed({1'b0, ip_r.mly})));
      naz = NEAR_Z;
    end
    lanes_nxt     = '0;
    lanes_nxt.vld = ip_r.vld;
    lanes_nxt.vis = ip_r.vis;
    if (ip_r.sel) begin
      lanes_nxt.ln[0].m = nax;       lanes_nxt.ln[0].z = naz;
      lanes_nxt.ln[1].m = nay;       lanes_nxt.ln[1].z = naz;
      lanes_nxt.ln[2].m = ip_r.bx;   lanes_nxt.ln[2].z = ip_r.bz;
      lanes_nxt.ln[3].m = ip_r.by;   lanes_nxt.ln[3].z = ip_r.bz;
    end else begin
      lanes_nxt.ln[0].m = ip_r.bx;   lanes_nxt.ln[0].z = ip_r.bz;
      lanes_nxt.ln[1].m = ip_r.by;   lanes_nxt.ln[1].z = ip_r.bz;
      lanes_nxt.ln[2].m = nax;       lanes_nxt.ln[2].z = naz;
      lanes_nxt.ln[3].m = nay;       lanes_nxt.ln[3].z = naz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lanes_r.vld <= 1'b0;
    end else begin
      lanes_r <= lanes_nxt;
    end
  end

  // pixel setup: sign, magnitude, saturation test (m holds the signed x or y in lanes_r)
  always_comb begin
    prep_nxt = lanes_r;
    for (int l = 0; l < 4; l++) begin
      lx[l] = $signed(lanes_r.ln[l].m);
      prep_nxt.ln[l].neg = lx[l][CAM_W-1];
      prep_nxt.ln[l].m   = lx[l][CAM_W-1] ? CAM_W'(-lx[l]) : lx[l];
      prep_nxt.ln[l].sat = CMP_W'(prep_nxt.ln[l].m)
                           >= (CMP_W'(lanes_r.ln[l].z) << (PIXEL_BITS - 1));
      prep_nxt.ln[l].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r[0].vld <= 1'b0;
    end else begin
      pix_r[0] <= prep_nxt;
    end
  end

  // pixel quotient: one bit per stage, most significant first
  for (genvar j = 0; j < PSTEPS; j++) begin : g_pix
    localparam int SH = PSTEPS - 1 - j;
    pix_st_t pstep_nxt;
    logic [CMP_W-1:0] sub [4];
    logic             ge  [4];

    always_comb begin
      pstep_nxt = pix_r[j];
      for (int l = 0; l < 4; l++) begin
        sub[l] = CMP_W'(pix_r[j].ln[l].z) << SH;
        ge[l]  = CMP_W'(pix_r[j].ln[l].m) >= sub[l];
        if (ge[l]) begin
          pstep_nxt.ln[l].m = CAM_W'(CMP_W'(pix_r[j].ln[l].m) - sub[l]);
        end
        pstep_nxt.ln[l].q[SH] = ge[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pix_r[j+1].vld <= 1'b0;
      end else begin
        pix_r[j+1] <= pstep_nxt;
      end
    end
  end

  // output register
  pix_st_t fin;
  logic signed [PIXEL_BITS-1:0] px [4];
  spnc_out_t out_nxt;
  logic out_valid_r;
  spnc_out_t out_data_r;

  always_comb begin
    fin = pix_r[PSTEPS];
    for (int l = 0; l < 4; l++) begin
      if (!fin.vis) begin
        px[l] = '0;
      end else if (fin.ln[l].sat) begin
        px[l] = fin.ln[l].neg ? PIX_MIN : PIX_MAX;
      end else if (fin.ln[l].neg) begin
        px[l] = -$signed({1'b0, fin.ln[l].q});
      end else begin
        px[l] = $signed({1'b0, fin.ln[l].q});
      end
    end
    out_nxt.visible = fin.vis;
    out_nxt.start_u = px[0];
    out_nxt.start_v = px[1];
    out_nxt.end_u   = px[2];
    out_nxt.end_v   = px[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.vld;
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: test/spnc_checker.sv
// Checker: predicts each segment's projection and compares it with the block's results.
`default_nettype none

module spnc_checker
  import spnc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire spnc_in_t             in_data,
  input  wire logic                 out_valid,
  input  wire spnc_out_t            out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    wide_t x;
    wide_t y;
    wide_t z;
  } cam_pt_t;

  localparam int PIX_MAX = 2 ** (PIXEL_BITS - 1) - 1;
  localparam int PIX_MIN = -(2 ** (PIXEL_BITS - 1));

  logic [CFG_W-1:0] matrix [CFG_REGS];
  spnc_out_t        projection_q [$];

  assign pending = projection_q.size();

  function automatic wide_t coef(int row, int col);
    logic [CFG_W-1:0] r;
    r = matrix[row * 2 + col / 2];
    if (col % 2) return wide_t'($signed(r[2*COEF_BITS-1:COEF_BITS]));
    return wide_t'($signed(r[COEF_BITS-1:0]));
  endfunction

  function automatic wide_t cam_row(int row, logic signed [COORD_BITS-1:0] px,
                                    logic signed [COORD_BITS-1:0] py,
                                    logic signed [COORD_BITS-1:0] pz);
    wide_t s;
    s = coef(row, 3) <<< FRAC_BITS;
    s = s + coef(row, 0) * wide_t'(px) + coef(row, 1) * wide_t'(py)
          + coef(row, 2) * wide_t'(pz);
    return s;
  endfunction

  function automatic cam_pt_t transform(logic signed [COORD_BITS-1:0] px,
                                        logic signed [COORD_BITS-1:0] py,
                                        logic signed [COORD_BITS-1:0] pz);
    cam_pt_t c;
    c.x = cam_row(0, px, py, pz);
    c.y = cam_row(1, px, py, pz);
    c.z = cam_row(2, px, py, pz);
    return c;
  endfunction

  // slide hidden point a toward visible point b onto the near plane
  function automatic cam_pt_t clip(cam_pt_t a, cam_pt_t b, wide_t nearz);
    wide_t    num, den, quot, tw;
    cam_pt_t  r;
    num  = nearz - a.z;
    den  = b.z - a.z;
    quot = (num <<< 32) / den;
    tw   = wide_t'({96'd0, quot[31:0]});
    r.x  = a.x + (((b.x - a.x) * tw) >>> 32);
    r.y  = a.y + (((b.y - a.y) * tw) >>> 32);
    r.z  = nearz;
    return r;
  endfunction

  function automatic logic signed [PIXEL_BITS-1:0] to_pixel(wide_t v, wide_t z);
    wide_t mag, q;
    logic  neg;
    neg = v < 0;
    mag = neg ? -v : v;
    if (mag >= (z <<< (PIXEL_BITS - 1)))
      return neg ? PIXEL_BITS'(PIX_MIN) : PIXEL_BITS'(PIX_MAX);
    q = mag / z;
    return neg ? -q[PIXEL_BITS-1:0] : q[PIXEL_BITS-1:0];
  endfunction

  function automatic spnc_out_t project_segment(spnc_in_t seg);
    cam_pt_t   p1, p2, c1, c2;
    wide_t     nearz;
    logic      vis1, vis2;
    spnc_out_t r;
    nearz = wide_t'(NEAR_Q);
    p1 = transform(seg.start_x, seg.start_y, seg.start_z);
    p2 = transform(seg.end_x, seg.end_y, seg.end_z);
    vis1 = p1.z > nearz;
    vis2 = p2.z > nearz;
    r = '0;
    if (!vis1 && !vis2) return r;
    c1 = vis1 ? p1 : clip(p1, p2, nearz);
    c2 = vis2 ? p2 : clip(p2, p1, nearz);
    r.visible = 1'b1;
    r.start_u = to_pixel(c1.x, c1.z);
    r.start_v = to_pixel(c1.y, c1.z);
    r.end_u   = to_pixel(c2.x, c2.z);
    r.end_v   = to_pixel(c2.y, c2.z);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      projection_q.delete();
      for (int i = 0; i < CFG_REGS; i++) matrix[i] <= '0;
    end else begin
      if (cfg_we && cfg_index < CFG_REGS) matrix[cfg_index] <= cfg_data;
      if (start && !busy) projection_q = {projection_q, project_segment(in_data)};
      if (out_valid) begin
        if (projection_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          spnc_out_t want;
          want = projection_q.pop_front();
          if (out_data.visible !== want.visible)
            report_mismatch("visible", out_data.visible, want.visible);
          if (out_data.start_u !== want.start_u)
            report_mismatch("start_u", out_data.start_u, want.start_u);
          if (out_data.start_v !== want.start_v)
            report_mismatch("start_v", out_data.start_v, want.start_v);
          if (out_data.end_u !== want.end_u)
            report_mismatch("end_u", out_data.end_u, want.end_u);
          if (out_data.end_v !== want.end_v)
            report_mismatch("end_v", out_data.end_v, want.end_v);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: test/testbench.sv
// Top of the segment projection testbench: clock, reset, stimulus and verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spnc_pkg::*;

  localparam int DRAIN_CYCLES = 70;
  localparam logic [COEF_BITS-1:0] ONE_Q = 32'h0001_0000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  spnc_in_t             in_data;
  logic                 out_valid;
  spnc_out_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;
  int                   sent;

  segment_projection_near_clip_core uut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  spnc_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [CFG_W-1:0] pair(int lo, int hi);
    return {hi[COEF_BITS-1:0], lo[COEF_BITS-1:0]};
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
      default: return int'($urandom_range(0, 40000)) - 20000;
    endcase
  endfunction

  // hold off until every expected result has left the pipeline
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_matrix(logic [CFG_W-1:0] m [CFG_REGS]);
    for (int i = 0; i < CFG_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= m[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic transfer(spnc_in_t seg);
    int idle_pct;
    idle_pct = (sent < 430) ? 18 : (sent < 860) ? 80 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= seg;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic send_random(int count);
    spnc_in_t seg;
    int       kxy, kz;
    repeat (count) begin
      kxy = $urandom_range(0, 9) < 2 ? 0 : 1;
      kz  = $urandom_range(0, 9);
      kz  = kz < 2 ? 0 : kz < 5 ? 1 : 2;
      seg.start_x = rand_coord(kxy);
      seg.start_y = rand_coord(kxy);
      seg.start_z = rand_coord(kz);
      seg.end_x   = rand_coord(kxy);
      seg.end_y   = rand_coord(kxy);
      seg.end_z   = rand_coord(kz);
      transfer(seg);
    end
  endtask

  task automatic send_directed();
    localparam logic signed [COORD_BITS-1:0] MAXC = 32'sh7fff_ffff;
    localparam logic signed [COORD_BITS-1:0] MINC = 32'sh8000_0000;
    spnc_in_t seg;
    seg = '0;
    transfer(seg);
    transfer({MAXC, MAXC, MAXC, MAXC, MAXC, MAXC});
    transfer({MINC, MINC, MINC, MINC, MINC, MINC});
    transfer({MAXC, MINC, MAXC, MINC, MAXC, MINC});
    // both behind the near plane
    transfer({32'sd65536, 32'sd0, -32'sd65536, 32'sd0, 32'sd65536, 32'sd100});
    // start hidden, end visible; then the reverse
    transfer({-32'sd65536, 32'sd65536, -32'sd131072, 32'sd65536, 32'sd0, 32'sd655360});
    transfer({32'sd65536, -32'sd65536, 32'sd655360, -32'sd65536, 32'sd0, -32'sd131072});
    // just around depth 0.1
    transfer({32'sd100, 32'sd100, 32'sd6553, 32'sd100, 32'sd100, 32'sd6554});
    transfer({32'sd100, 32'sd100, 32'sd6554, 32'sd100, 32'sd100, 32'sd6553});
    // saturating pixels (far off axis, shallow depth), then a segment close to the axis
    transfer({MAXC, MINC, 32'sd7000, MINC, MAXC, 32'sd7000});
    transfer({32'sd65536, 32'sd65536, 32'sd655360, MAXC, MAXC, 32'sd6600});
    transfer({-32'sd50, 32'sd50, 32'sd65536, 32'sd50, -32'sd50, 32'sd65536});
  endtask

  initial begin
    logic [CFG_W-1:0] m [CFG_REGS];
    sent      = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset matrix: everything sits on depth zero
    send_directed();
    send_random(20);
    drain();

    // pinhole camera, 500 px focal length
    m[REG_ROW0_A] = pair(500 << 16, 0);
    m[REG_ROW0_B] = pair(320 << 16, 0);
    m[REG_ROW1_A] = pair(0, 500 << 16);
    m[REG_ROW1_B] = pair(240 << 16, 0);
    m[REG_ROW2_A] = pair(0, 0);
    m[REG_ROW2_B] = pair(ONE_Q, 0);
    write_matrix(m);
    send_directed();
    drain();
    send_random(480);
    drain();

    foreach (m[i]) m[i] = {$urandom, $urandom};
    write_matrix(m);
    send_random(120);
    drain();

    foreach (m[i]) m[i] = {2{32'h7fff_ffff}};
    write_matrix(m);
    send_directed();
    send_random(60);
    drain();

    foreach (m[i]) m[i] = {2{32'h8000_0000}};
    write_matrix(m);
    send_directed();
    send_random(60);
    drain();

    // tilted camera with an offset, depth rows small so clipping is common
    m[REG_ROW0_A] = pair(800 << 16, -(20 << 16));
    m[REG_ROW0_B] = pair(100 << 16, -(3 << 16));
    m[REG_ROW1_A] = pair(15 << 16, 700 << 16);
    m[REG_ROW1_B] = pair(-(50 << 16), 7 << 16);
    m[REG_ROW2_A] = pair(3000, -2000);
    m[REG_ROW2_B] = pair(ONE_Q, -(1 << 12));
    write_matrix(m);
    send_directed();
    send_random(500);

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
